[rtl/rrt_pkg.sv]
`timescale 1ns / 1ps

package rrt_pkg;

	// default sizing
	localparam int unsigned DEF_TABLE_ENTRIES = 16;
	localparam int unsigned DEF_ADDR_BITS     = 32;

	localparam int unsigned REG_W    = 32;
	localparam int unsigned CMD_W    = 2;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned HELD_W   = 5;

	localparam logic [REG_W-1:0] WIN_LOW_RESET  = 32'h0000_0000;
	localparam logic [REG_W-1:0] WIN_HIGH_RESET = 32'hFFFF_FFFF;

	// register indexes
	localparam logic REG_WIN_LOW  = 1'b0;
	localparam logic REG_WIN_HIGH = 1'b1;

	// commands
	localparam logic [CMD_W-1:0] CMD_REQUEST = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CHECK   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BUSY     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

endpackage

[rtl/range_reservation_table_top.sv]
`timescale 1ns / 1ps

// Range reservation table: holds up to TABLE_ENTRIES non-overlapping address
// ranges, sorted by start, all inside the window [window_low, window_high].
// Input channel (in_valid/in_ready) carries one command word: request, check
// or release, with range_start and range_length. Output channel
// (out_valid/out_ready) returns one word per command: status and the number
// of ranges held afterwards.
// Configuration: cfg_we writes cfg_data to window_low (index 0) or
// window_high (index 1) in the same cycle; write only while the block is idle.
// Timing: one command at a time. A taken word is first checked on its own
// fields; one refused there, or any word on an empty table, goes straight to
// the result (a request on an empty table writes its entry first). Otherwise
// the compare logic walks the table one entry per cycle, then an insert moves
// the entries above the slot up and a release moves those above the match
// down, one per cycle through the single read and write port of the entry
// memory. The longest command is an insert at the front of a table one short
// of full; the next word is taken in the cycle after the result is loaded.
// Reset empties the table and restores the full window. A stalled receiver
// holds the result in the output register; the next command is still taken
// and finishes as far as its own result, which waits for the register to free.

module range_reservation_table_top #(
	parameter int unsigned TABLE_ENTRIES = rrt_pkg::DEF_TABLE_ENTRIES,
	parameter int unsigned ADDR_BITS     = rrt_pkg::DEF_ADDR_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [rrt_pkg::REG_W-1:0]      cfg_data,
	// command words
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [rrt_pkg::CMD_W-1:0]      cmd,
	input  logic [rrt_pkg::REG_W-1:0]      range_start,
	input  logic [rrt_pkg::REG_W-1:0]      range_length,
	// result words
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [rrt_pkg::STATUS_W-1:0]   status,
	output logic [rrt_pkg::HELD_W-1:0]     entries_held
);

	localparam int unsigned AW    = ADDR_BITS;
	localparam int unsigned IW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
	// compare width wide enough for both addresses and window registers
	localparam int unsigned WW    = AW + rrt_pkg::REG_W;

	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_ENTRIES);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
	localparam logic [IW-1:0]    IDX_ONE  = IW'(1);

	// sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_SHUP  = 3'd3;
	localparam logic [2:0] S_PUT   = 3'd4;
	localparam logic [2:0] S_SHDN  = 3'd5;
	localparam logic [2:0] S_FIN   = 3'd6;

	logic [2:0] state_q, state_d;

	// window registers
	logic [rrt_pkg::REG_W-1:0] win_low_q, win_high_q;

	// command word held for the whole walk
	logic [rrt_pkg::CMD_W-1:0] cmd_q;
	logic [AW-1:0]             start_q, len_q, last_q;

	logic [IW-1:0]    idx_q, idx_d;
	logic [IW-1:0]    sh_idx_q, sh_idx_d;
	logic [CNT_W-1:0] pos_q, pos_d;
	logic [CNT_W-1:0] held_q, held_d;
	logic [rrt_pkg::STATUS_W-1:0] res_q, res_d;

	// entry memory: one read, one write port, registered read data
	logic [AW-1:0] first_mem [TABLE_ENTRIES];
	logic [AW-1:0] last_mem  [TABLE_ENTRIES];
	logic [AW-1:0] rd_first_q, rd_last_q;
	logic [IW-1:0] rd_addr, wr_addr;
	logic          wr_en;
	logic [AW-1:0] wr_first, wr_last;

	// output register
	logic                          out_valid_q;
	logic [rrt_pkg::STATUS_W-1:0]  status_q;
	logic [rrt_pkg::HELD_W-1:0]    held_out_q;
	logic                          out_load;

	// range arithmetic on the held command
	logic [AW:0]   sum;
	logic [AW-1:0] last_c;
	logic          len_bad, win_bad;
	logic          verdict_free;
	logic [CNT_W-1:0] idx_cnt, sh_cnt;
	logic          scan_end, shdn_end;

	assign sum     = {1'b0, start_q} + {1'b0, len_q} - (AW+1)'(1);
	assign last_c  = sum[AW-1:0];
	// zero length, or last address wraps past the address width
	assign len_bad = (len_q == '0) || sum[AW];
	assign win_bad = (WW'(start_q) < WW'(win_low_q)) || (WW'(last_c) > WW'(win_high_q));

	assign idx_cnt  = CNT_W'(idx_q);
	assign sh_cnt   = CNT_W'(sh_idx_q);
	assign scan_end = (idx_cnt == held_q - CNT_ONE);
	assign shdn_end = (sh_cnt == held_q - CNT_ONE);

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d      = state_q;
		idx_d        = idx_q;
		sh_idx_d     = sh_idx_q;
		pos_d        = pos_q;
		held_d       = held_q;
		res_d        = res_q;
		rd_addr      = idx_q + IDX_ONE;
		wr_en        = 1'b0;
		wr_addr      = sh_idx_q;
		wr_first     = rd_first_q;
		wr_last      = rd_last_q;
		verdict_free = 1'b0;
		out_load     = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				// prime the read of entry 0 for the walk
				rd_addr = '0;
				idx_d   = '0;
				unique case (cmd_q) inside
					rrt_pkg::CMD_REQUEST, rrt_pkg::CMD_CHECK: begin
						if (len_bad || win_bad) begin
							res_d   = rrt_pkg::ST_INVALID;
							state_d = S_FIN;
						end else if (held_q == '0) begin
							pos_d        = '0;
							verdict_free = 1'b1;
						end else begin
							state_d = S_SCAN;
						end
					end
					rrt_pkg::CMD_RELEASE: begin
						if (len_bad || (held_q == '0)) begin
							res_d   = rrt_pkg::ST_NOTFOUND;
							state_d = S_FIN;
						end else begin
							state_d = S_SCAN;
						end
					end
					default: begin
						res_d   = rrt_pkg::ST_INVALID;
						state_d = S_FIN;
					end
				endcase
			end
			S_SCAN: begin
				// rd_*_q holds entry idx_q; entry idx_q+1 is being read
				if (cmd_q == rrt_pkg::CMD_RELEASE) begin
					if ((rd_first_q == start_q) && (rd_last_q == last_q)) begin
						if (scan_end) begin
							held_d  = held_q - CNT_ONE;
							res_d   = rrt_pkg::ST_OK;
							state_d = S_FIN;
						end else begin
							sh_idx_d = idx_q + IDX_ONE;
							state_d  = S_SHDN;
						end
					end else if (scan_end) begin
						res_d   = rrt_pkg::ST_NOTFOUND;
						state_d = S_FIN;
					end else begin
						idx_d = idx_q + IDX_ONE;
					end
				end else begin
					if (rd_first_q > last_q) begin
						pos_d        = idx_cnt;
						verdict_free = 1'b1;
					end else if (rd_last_q >= start_q) begin
						res_d   = rrt_pkg::ST_BUSY;
						state_d = S_FIN;
					end else if (scan_end) begin
						pos_d        = held_q;
						verdict_free = 1'b1;
					end else begin
						idx_d = idx_q + IDX_ONE;
					end
				end
			end
			S_SHUP: begin
				// move entry sh_idx_q up one place, walking down to the slot
				rd_addr = sh_idx_q - IDX_ONE;
				wr_en   = 1'b1;
				wr_addr = sh_idx_q + IDX_ONE;
				if (sh_cnt == pos_q) begin
					state_d = S_PUT;
				end else begin
					sh_idx_d = sh_idx_q - IDX_ONE;
				end
			end
			S_PUT: begin
				wr_en    = 1'b1;
				wr_addr  = IW'(pos_q);
				wr_first = start_q;
				wr_last  = last_q;
				held_d   = held_q + CNT_ONE;
				res_d    = rrt_pkg::ST_OK;
				state_d  = S_FIN;
			end
			S_SHDN: begin
				// move entry sh_idx_q down one place over the removed one
				rd_addr = sh_idx_q + IDX_ONE;
				wr_en   = 1'b1;
				wr_addr = sh_idx_q - IDX_ONE;
				if (shdn_end) begin
					held_d  = held_q - CNT_ONE;
					res_d   = rrt_pkg::ST_OK;
					state_d = S_FIN;
				end else begin
					sh_idx_d = sh_idx_q + IDX_ONE;
				end
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// range is free: full check, then insert for a request or OK for a check
		if (verdict_free) begin
			if (held_q == CNT_FULL) begin
				res_d   = rrt_pkg::ST_FULL;
				state_d = S_FIN;
			end else if (cmd_q == rrt_pkg::CMD_REQUEST) begin
				if (pos_d == held_q) begin
					state_d = S_PUT;
				end else begin
					sh_idx_d = IW'(held_q - CNT_ONE);
					rd_addr  = IW'(held_q - CNT_ONE);
					state_d  = S_SHUP;
				end
			end else begin
				res_d   = rrt_pkg::ST_OK;
				state_d = S_FIN;
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			held_q      <= '0;
			out_valid_q <= 1'b0;
			win_low_q   <= rrt_pkg::WIN_LOW_RESET;
			win_high_q  <= rrt_pkg::WIN_HIGH_RESET;
		end else begin
			state_q <= state_d;
			held_q  <= held_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					rrt_pkg::REG_WIN_LOW:  win_low_q  <= cfg_data;
					rrt_pkg::REG_WIN_HIGH: win_high_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		idx_q    <= idx_d;
		sh_idx_q <= sh_idx_d;
		pos_q    <= pos_d;
		res_q    <= res_d;
		if (in_valid && in_ready) begin
			cmd_q   <= cmd;
			start_q <= AW'(range_start);
			len_q   <= AW'(range_length);
		end
		if (state_q == S_CHECK) begin
			last_q <= last_c;
		end
		if (out_load) begin
			status_q   <= res_q;
			held_out_q <= rrt_pkg::HELD_W'(held_q);
		end
	end

	// entry memory
	always_ff @(posedge clk) begin
		rd_first_q <= first_mem[rd_addr];
		rd_last_q  <= last_mem[rd_addr];
		if (wr_en) begin
			first_mem[wr_addr] <= wr_first;
			last_mem[wr_addr]  <= wr_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign entries_held = held_out_q;

endmodule
